// File: rtl/core/psched_pkg.sv
`default_nettype none

package psched_pkg;

   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_OUT_W  = 3;
   localparam int TIME_W      = 16;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_CREATE   = 2'd1,
      OP_DISPATCH = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_DISP
   } state_type;

   localparam logic KIND_CREATE = 1'b0;
   localparam logic KIND_TASK   = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_ERR  = 1'b1;

   typedef struct packed {
      logic create;
      logic tick_start;
      logic tick_step;
      logic disp_start;
      logic disp_step;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/core/psched_ctrl.sv
`default_nettype none

module psched_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          opcode,
   input  wire psched_pkg::stat_type stat,
   output logic                     busy,
   output psched_pkg::cmd_type      cmd
);

   psched_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psched_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         psched_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (psched_pkg::opcode_type'(opcode))
                  psched_pkg::OP_TICK: begin
                     cmd.tick_start = 1'b1;
                     state_in       = psched_pkg::ST_TICK;
                  end
                  psched_pkg::OP_CREATE: begin
                     cmd.create = 1'b1;
                  end
                  psched_pkg::OP_DISPATCH: begin
                     cmd.disp_start = 1'b1;
                     state_in       = psched_pkg::ST_DISP;
                  end
                  default: begin
                     state_in = psched_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         psched_pkg::ST_TICK: begin
            cmd.tick_step = 1'b1;
            if (stat.scan_done) begin
               state_in = psched_pkg::ST_IDLE;
            end
         end
         psched_pkg::ST_DISP: begin
            cmd.disp_step = 1'b1;
            if (stat.scan_done) begin
               state_in = psched_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psched_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/psched_dp.sv
`default_nettype none

module psched_dp #(
   parameter int TASKS = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire psched_pkg::cmd_type                     cmd,
   output psched_pkg::stat_type                         stat,
   input  wire logic [7:0]                              req_slot_index,
   input  wire logic [psched_pkg::TIME_W-1:0]           req_period_ticks,
   input  wire logic                                    req_has_handler,
   output logic                                         rsp_valid,
   output logic                                         rsp_result_kind,
   output logic                                         rsp_status,
   output logic [psched_pkg::SLOT_OUT_W-1:0]            rsp_task_slot,
   output logic                                         rsp_last
);

   localparam int TW = psched_pkg::TIME_W;
   localparam int OW = psched_pkg::SLOT_OUT_W;
   localparam int CW = psched_pkg::CNT_W;
   localparam int IW = $clog2(TASKS + 1);
   localparam int SW = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam logic [IW-1:0] TASKS_I = IW'(TASKS);
   localparam logic [7:0]    TASKS_B = 8'(TASKS);
   localparam logic [CW-1:0] MAX_C   = CW'(psched_pkg::MAX_RESULTS);

   // period in the upper half, down-counter in the lower half
   logic [2*TW-1:0] mem [TASKS];

   logic [IW-1:0]    idx_ff, idx_in;
   logic [TASKS-1:0] exists_ff, exists_in;
   logic [TASKS-1:0] ready_ff, ready_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [SW-1:0]    rd_slot_ff;
   logic [2*TW-1:0]  rd_data_ff;
   logic [CW-1:0]    found_ff, found_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [SW-1:0]    pend_slot_ff, pend_slot_in;
   logic             out_vld_ff, out_vld_in;
   logic             out_kind_ff, out_kind_in;
   logic             out_stat_ff, out_stat_in;
   logic [OW-1:0]    out_slot_ff, out_slot_in;
   logic             out_last_ff, out_last_in;

   logic             in_range;
   logic [SW-1:0]    sp;
   logic             hit;
   logic             create_ok;
   logic [SW-1:0]    cslot;
   logic             mem_we;
   logic [SW-1:0]    mem_wa;
   logic [2*TW-1:0]  mem_wd;
   logic [TW-1:0]    rd_period;
   logic [TW-1:0]    rd_count;
   logic [SW+OW-1:0] pend_ext;

   assign in_range       = idx_ff < TASKS_I;
   assign sp             = idx_ff[SW-1:0];
   assign stat.scan_done = idx_ff == TASKS_I;
   assign create_ok      = (req_slot_index < TASKS_B) && req_has_handler;
   assign cslot          = req_slot_index[SW-1:0];
   assign rd_period      = rd_data_ff[2*TW-1:TW];
   assign rd_count       = rd_data_ff[TW-1:0];
   assign hit            = cmd.disp_step && in_range && exists_ff[sp] && ready_ff[sp]
                           && (found_ff < MAX_C);
   assign pend_ext       = {{OW{1'b0}}, pend_slot_ff};

   always_comb begin
      idx_in       = idx_ff;
      exists_in    = exists_ff;
      ready_in     = ready_ff;
      rd_vld_in    = 1'b0;
      found_in     = found_ff;
      pend_vld_in  = pend_vld_ff;
      pend_slot_in = pend_slot_ff;
      out_vld_in   = 1'b0;
      out_kind_in  = out_kind_ff;
      out_stat_in  = out_stat_ff;
      out_slot_in  = out_slot_ff;
      out_last_in  = out_last_ff;
      mem_we       = 1'b0;
      mem_wa       = rd_slot_ff;
      mem_wd       = rd_data_ff;

      if (cmd.tick_start || cmd.disp_start) begin
         idx_in      = '0;
         found_in    = '0;
         pend_vld_in = 1'b0;
      end

      if (cmd.create) begin
         out_vld_in  = 1'b1;
         out_kind_in = psched_pkg::KIND_CREATE;
         out_stat_in = create_ok ? psched_pkg::STATUS_OK : psched_pkg::STATUS_ERR;
         out_slot_in = req_slot_index[OW-1:0];
         out_last_in = 1'b1;
         if (create_ok) begin
            exists_in[cslot] = 1'b1;
            ready_in[cslot]  = 1'b0;
            mem_we           = 1'b1;
            mem_wa           = cslot;
            mem_wd           = {req_period_ticks, {TW{1'b0}}};
         end
      end

      // read slot i while writing back slot i-1
      if (cmd.tick_step && in_range) begin
         rd_vld_in = 1'b1;
         idx_in    = idx_ff + IW'(1);
      end
      if (rd_vld_ff && exists_ff[rd_slot_ff]) begin
         mem_we = 1'b1;
         mem_wa = rd_slot_ff;
         if (rd_count == '0) begin
            ready_in[rd_slot_ff] = 1'b1;
            mem_wd               = {rd_period, rd_period};
         end else begin
            mem_wd = {rd_period, rd_count - TW'(1)};
         end
      end

      if (cmd.disp_step) begin
         if (in_range) begin
            idx_in = idx_ff + IW'(1);
         end
         if (hit) begin
            ready_in[sp] = 1'b0;
            found_in     = found_ff + CW'(1);
            pend_vld_in  = 1'b1;
            pend_slot_in = sp;
         end
         if (pend_vld_ff && (hit || stat.scan_done)) begin
            out_vld_in  = 1'b1;
            out_kind_in = psched_pkg::KIND_TASK;
            out_stat_in = psched_pkg::STATUS_OK;
            out_slot_in = pend_ext[OW-1:0];
            out_last_in = stat.scan_done;
         end
         if (stat.scan_done) begin
            pend_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         exists_ff   <= '0;
         ready_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         found_ff    <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         exists_ff   <= exists_in;
         ready_ff    <= ready_in;
         rd_vld_ff   <= rd_vld_in;
         found_ff    <= found_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff   <= sp;
      pend_slot_ff <= pend_slot_in;
      out_kind_ff  <= out_kind_in;
      out_stat_ff  <= out_stat_in;
      out_slot_ff  <= out_slot_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_vld_in) begin
         rd_data_ff <= mem[sp];
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_status      = out_stat_ff;
   assign rsp_task_slot   = out_slot_ff;
   assign rsp_last        = out_last_ff;

endmodule

`default_nettype wire

// File: rtl/core/periodic_task_scheduler.sv
// create: one beat, result strobed on the cycle after acceptance, busy never raised
// tick: busy while every slot is scanned, one slot a cycle through the period/counter memory port
// dispatch: busy while scanning one slot a cycle; up to MAX_RESULTS ready slots come out one
// beat each, the final one in the same cycle busy falls; the receiver cannot stall
// synchronous active-high reset clears slot exists/ready flags and the controller;
// period/counter memory is not cleared, entries are gated by the exists flag
`default_nettype none

module periodic_task_scheduler #(
   parameter int TASKS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_opcode,
   input  wire logic [7:0]                         req_slot_index,
   input  wire logic [psched_pkg::TIME_W-1:0]      req_period_ticks,
   input  wire logic                               req_has_handler,
   output logic                                    rsp_valid,
   output logic                                    rsp_result_kind,
   output logic                                    rsp_status,
   output logic [psched_pkg::SLOT_OUT_W-1:0]       rsp_task_slot,
   output logic                                    rsp_last
);

   psched_pkg::cmd_type  cmd;
   psched_pkg::stat_type stat;

   psched_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   psched_dp #(
      .TASKS (TASKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_slot_index   (req_slot_index),
      .req_period_ticks (req_period_ticks),
      .req_has_handler  (req_has_handler),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_status       (rsp_status),
      .rsp_task_slot    (rsp_task_slot),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
